>>> hdl/three_phase_sine_pwm_stepper_top_macros.svh
// Assertion macros for the three-phase sine PWM stepper.
// Included by the modules that carry assertions; no other dependencies.
`ifndef THREE_PHASE_SINE_PWM_STEPPER_TOP_MACROS_SVH
`define THREE_PHASE_SINE_PWM_STEPPER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// expr holds at every clock edge out of reset
`define SPS_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
// ante implies cons in the same cycle
`define SPS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// ante implies cons in the next cycle
`define SPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SPS_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define SPS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/sps_pkg.sv
// Package for the three-phase sine PWM stepper: payload structs, codes, constants.
// No dependencies.
package sps_pkg;

    localparam int CFG_IDX_W   = 2;
    localparam int SLOT_W      = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int NUM_LANES   = 6;

    localparam logic [15:0] INITIAL_TARGET_RESET = 16'd1143;
    localparam logic [15:0] DUTY_SCALE_RESET     = 16'd19661;
    localparam logic [15:0] PERIOD_STEP          = 16'd2;
    localparam logic [15:0] PERIOD_MAX           = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_TARGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_SCALE     = 2'd1;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_HALVE = 2'd1,
        CMD_WRITE = 2'd2
    } t_cmd;

    typedef enum logic {
        JOB_TICK  = 1'b0,
        JOB_WRITE = 1'b1
    } t_job_kind;

    typedef logic [SLOT_W-1:0] t_slot;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [4:0]  entry_addr;
        logic [15:0] entry_value;
    } t_in;

    typedef struct packed {
        logic [15:0] u_high;
        logic [15:0] u_low;
        logic [15:0] v_high;
        logic [15:0] v_low;
        logic [15:0] w_high;
        logic [15:0] w_low;
        logic [15:0] step_period;
    } t_out;

    // tick: addr = position, value = period; write: addr = entry, value = data
    typedef struct packed {
        t_job_kind   kind;
        t_slot       addr;
        logic [15:0] value;
    } t_job;

    typedef struct packed {
        logic        load;
        logic [15:0] value;
    } t_cfg_load;

endpackage

>>> hdl/sps_queue.sv
// Short job queue between front and back of the sine PWM stepper.
// Depends on sps_pkg and the assertion macro header.
`include "three_phase_sine_pwm_stepper_top_macros.svh"
module sps_queue
    import sps_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_head
);

    t_job              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    `SPS_ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, r_cnt <= (QPTR_W+1)'(QUEUE_DEPTH))
    `SPS_ASSERT_NEXT(a_cnt_inc, i_clk, i_rst_n, i_push && !i_pop, r_cnt == $past(r_cnt) + 1'b1)

endmodule

>>> hdl/sps_front.sv
// Front of the sine PWM stepper: accepts beats, keeps period/target/position,
// and queues table writes and ticks. Depends on sps_pkg and the macro header.
`include "three_phase_sine_pwm_stepper_top_macros.svh"
module sps_front
    import sps_pkg::*;
#(
    parameter int STEPS = 30
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in       i_in,
    output logic      o_in_stall,
    input  t_cfg_load i_cfg,
    input  logic      i_q_full,
    output logic      o_push,
    output t_job      o_job
);

    localparam int PW = $clog2(STEPS);

    logic [15:0]   r_target;
    logic [15:0]   r_period;
    logic [PW-1:0] r_pos;
    logic [15:0]   n_target;
    logic [15:0]   n_period;
    logic [PW-1:0] n_pos;

    logic          accept;
    logic [15:0]   p_up;
    logic [15:0]   p_dn;
    logic [15:0]   p_adj;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    always_comb begin
        p_up = r_period;
        if (r_target > r_period) begin
            p_up = (r_period >= PERIOD_MAX - 16'd1) ? PERIOD_MAX : r_period + PERIOD_STEP;
        end
        p_dn = p_up;
        if (r_target < p_up) begin
            p_dn = (p_up <= PERIOD_STEP) ? '0 : p_up - PERIOD_STEP;
        end
        p_adj = (r_pos == '0) ? p_dn : r_period;
    end

    always_comb begin
        n_target   = r_target;
        n_period   = r_period;
        n_pos      = r_pos;
        o_push     = 1'b0;
        o_job      = '0;
        if (i_cfg.load) begin
            n_target = i_cfg.value;
            n_period = i_cfg.value;
        end else if (accept) begin
            unique case (i_in.cmd)
                CMD_TICK: begin
                    n_period    = p_adj;
                    n_pos       = (r_pos == PW'(STEPS - 1)) ? '0 : r_pos + 1'b1;
                    o_push      = 1'b1;
                    o_job.kind  = JOB_TICK;
                    o_job.addr  = t_slot'(r_pos);
                    o_job.value = p_adj;
                end
                CMD_HALVE: begin
                    n_target = r_target >> 1;
                end
                CMD_WRITE: begin
                    if (int'(i_in.entry_addr) < STEPS) begin
                        o_push      = 1'b1;
                        o_job.kind  = JOB_WRITE;
                        o_job.addr  = t_slot'(i_in.entry_addr);
                        o_job.value = i_in.entry_value;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= INITIAL_TARGET_RESET;
            r_period <= INITIAL_TARGET_RESET;
            r_pos    <= '0;
        end else begin
            r_target <= n_target;
            r_period <= n_period;
            r_pos    <= n_pos;
        end
    end

    `SPS_ASSERT_NEXT(a_period_hold, i_clk, i_rst_n, accept && !i_cfg.load && (i_in.cmd == CMD_TICK) && (r_pos != '0), $stable(r_period))

endmodule

>>> hdl/sps_back.sv
// Back of the sine PWM stepper: six table copies, scaling multipliers and
// the output register. Depends on sps_pkg and the macro header.
`include "three_phase_sine_pwm_stepper_top_macros.svh"
module sps_back
    import sps_pkg::*;
#(
    parameter int STEPS = 30
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_job        i_head,
    output logic        o_pop,
    input  logic [15:0] i_duty_scale,
    output logic        o_out_valid,
    output t_out        o_out,
    input  logic        i_out_stall
);

    localparam int PW = $clog2(STEPS);
    localparam int OFFSET [NUM_LANES] = '{0, STEPS/2, STEPS/3, (5*STEPS)/6, (2*STEPS)/3, STEPS/6};

    logic          can_s1;
    logic          can_s2;
    logic          rd_en;
    logic          wr_en;
    logic [PW-1:0] head_pos;

    logic          r_s1_vld;
    logic [15:0]   r_s1_period;
    logic [15:0]   r_rd [NUM_LANES];
    logic [31:0]   prod [NUM_LANES];

    logic          r_s2_vld;
    t_out          r_out;
    t_out          n_out;

    assign can_s2   = !r_s2_vld || !i_out_stall;
    assign can_s1   = !r_s1_vld || can_s2;
    assign o_pop    = !i_q_empty && ((i_head.kind == JOB_WRITE) || can_s1);
    assign rd_en    = o_pop && (i_head.kind == JOB_TICK);
    assign wr_en    = o_pop && (i_head.kind == JOB_WRITE);
    assign head_pos = i_head.addr[PW-1:0];

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        logic [15:0] r_mem [STEPS];
        logic [PW:0] sum;
        logic [PW-1:0] rd_addr;

        assign sum     = {1'b0, head_pos} + (PW+1)'(OFFSET[g]);
        assign rd_addr = (sum >= (PW+1)'(STEPS)) ? PW'(sum - (PW+1)'(STEPS)) : sum[PW-1:0];

        always_ff @(posedge i_clk) begin
            if (wr_en) begin
                r_mem[head_pos] <= i_head.value;
            end
            if (rd_en) begin
                r_rd[g] <= r_mem[rd_addr];
            end
        end

        assign prod[g] = 32'(r_rd[g]) * 32'(i_duty_scale);
    end

    always_comb begin
        n_out.u_high      = prod[0][31:16];
        n_out.u_low       = prod[1][31:16];
        n_out.v_high      = prod[2][31:16];
        n_out.v_low       = prod[3][31:16];
        n_out.w_high      = prod[4][31:16];
        n_out.w_low       = prod[5][31:16];
        n_out.step_period = r_s1_period;
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_s1_period <= i_head.value;
        end
        if (can_s2 && r_s1_vld) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            if (can_s1) begin
                r_s1_vld <= rd_en;
            end
            if (can_s2) begin
                r_s2_vld <= r_s1_vld;
            end
        end
    end

    assign o_out_valid = r_s2_vld;
    assign o_out       = r_out;

    `SPS_ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1_vld && !can_s2, r_s1_vld && $stable(r_s1_period))

endmodule

>>> hdl/three_phase_sine_pwm_stepper_top.sv
// Top level of the three-phase sine PWM stepper: configuration registers,
// front, job queue and back. Depends on sps_pkg, sps_front, sps_queue, sps_back.
//
// Input channel (i_in_valid / o_in_stall, payload i_in): cmd 0 is an update
// tick, cmd 1 halves the target period, cmd 2 writes one sine table entry.
// Only a tick yields a result beat on the output channel (o_out_valid /
// i_out_stall, payload o_out): six compare values and the step period.
// Config channel (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data):
// index 0 loads initial target into target and period, index 1 sets the
// duty scale; o_cfg_ready is always high. Write only while idle.
// Throughput: one input beat per cycle while o_in_stall is low. A tick passes
// the queue slot, then the table read, then the multiply/output reg to result valid.
// Six table copies, each one write and one read port, give the six reads.
// Reset: target and period at 1143, duty scale 19661, position 0, queue and
// pipeline empty; table contents stay undefined until written.
// A stalled output holds its beat; the 4-deep queue keeps accepting until
// full, then o_in_stall rises.
module three_phase_sine_pwm_stepper_top
    import sps_pkg::*;
#(
    parameter int STEPS = 30
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  t_in                  i_in,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output t_out                 o_out,
    input  logic                 i_out_stall,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    logic        duty_wr;
    logic [15:0] r_duty;
    t_cfg_load   cfg_load;
    logic        cfg_wr;

    logic        q_push;
    t_job        q_job;
    logic        q_full;
    logic        q_pop;
    logic        q_empty;
    t_job        q_head;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_comb begin
        cfg_load     = '0;
        duty_wr      = 1'b0;
        cfg_load.value = i_cfg_data;
        if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_INITIAL_TARGET: cfg_load.load = 1'b1;
                CFG_DUTY_SCALE:     duty_wr       = 1'b1;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty <= DUTY_SCALE_RESET;
        end else if (duty_wr) begin
            r_duty <= i_cfg_data;
        end
    end

    sps_front #(
        .STEPS(STEPS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_stall (o_in_stall),
        .i_cfg      (cfg_load),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_job      (q_job)
    );

    sps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    sps_back #(
        .STEPS(STEPS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .i_duty_scale (r_duty),
        .o_out_valid  (o_out_valid),
        .o_out        (o_out),
        .i_out_stall  (i_out_stall)
    );

endmodule

>>> tb/tb_top.sv
// Testbench for the three-phase sine PWM stepper: random and directed command beats
// are checked against an in-bench predictor of table, period and position state.
// Depends on sps_pkg and three_phase_sine_pwm_stepper_top.
`timescale 1ns / 100ps

module tb_top;
    import sps_pkg::*;

    localparam int STEPS = 30;
    localparam int OFS_U_LOW  = STEPS / 2;
    localparam int OFS_V_HIGH = STEPS / 3;
    localparam int OFS_V_LOW  = (5 * STEPS) / 6;
    localparam int OFS_W_HIGH = (2 * STEPS) / 3;
    localparam int OFS_W_LOW  = STEPS / 6;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 12;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    t_in                  i_in;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out                 o_out;
    logic                 i_out_stall;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [15:0]          i_cfg_data;

    three_phase_sine_pwm_stepper_top #(
        .STEPS(STEPS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predicted stepper state
    logic [15:0] wave_shadow [STEPS];
    logic [15:0] tgt_period;
    logic [15:0] cur_period;
    logic [15:0] duty_now;
    int unsigned pos_now;

    t_out pending_compares[$];
    int   mismatch_count = 0;
    bit   gaps_on = 1'b1;
    int   out_hold_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(64'd12_000_000);
        $display("simulation failed");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(1, 4);
        if (r < 97) return $urandom_range(5, 15);
        return $urandom_range(30, 80);
    endfunction

    function automatic int send_gap();
        if (!gaps_on || $urandom_range(0, 99) < 50) return 0;
        return idle_len();
    endfunction

    function automatic logic [15:0] compare_value(input int unsigned offset);
        logic [31:0] prod;
        prod = 32'(duty_now) * 32'(wave_shadow[(pos_now + offset) % STEPS]);
        return prod[31:16];
    endfunction

    function automatic void advance_stepper(input t_in beat);
        t_out res;
        case (beat.cmd)
            CMD_HALVE: tgt_period = tgt_period >> 1;
            CMD_WRITE: if (beat.entry_addr < STEPS) wave_shadow[beat.entry_addr] = beat.entry_value;
            CMD_TICK: begin
                if (pos_now == 0) begin
                    if (tgt_period > cur_period)
                        cur_period = (cur_period > PERIOD_MAX - PERIOD_STEP) ? PERIOD_MAX
                                                                           : cur_period + PERIOD_STEP;
                    if (tgt_period < cur_period)
                        cur_period = (cur_period <= PERIOD_STEP) ? 16'd0 : cur_period - PERIOD_STEP;
                end
                res.u_high      = compare_value(0);
                res.u_low       = compare_value(OFS_U_LOW);
                res.v_high      = compare_value(OFS_V_HIGH);
                res.v_low       = compare_value(OFS_V_LOW);
                res.w_high      = compare_value(OFS_W_HIGH);
                res.w_low       = compare_value(OFS_W_LOW);
                res.step_period = cur_period;
                pending_compares.push_back(res);
                pos_now = (pos_now == STEPS - 1) ? 0 : pos_now + 1;
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_compares.size() == 0) begin
                mismatch_count++;
                $display("%0t: result beat expected none actual %h", $time, o_out);
            end else begin
                want = pending_compares.pop_front();
                check_field("u_high", want.u_high, o_out.u_high);
                check_field("u_low", want.u_low, o_out.u_low);
                check_field("v_high", want.v_high, o_out.v_high);
                check_field("v_low", want.v_low, o_out.v_low);
                check_field("w_high", want.w_high, o_out.w_high);
                check_field("w_low", want.w_low, o_out.w_low);
                check_field("step_period", want.step_period, o_out.step_period);
            end
        end
    end

    // output stall: random runs, a counted long hold on request
    initial begin
        int run_len;
        run_len = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                out_hold_cycles--;
                run_len = 0;
            end else if (!gaps_on) begin
                i_out_stall <= 1'b0;
            end else if (run_len > 0) begin
                run_len--;
            end else if ($urandom_range(0, 99) < 35) begin
                i_out_stall <= 1'b1;
                run_len = idle_len() - 1;
            end else begin
                i_out_stall <= 1'b0;
                run_len = $urandom_range(0, 12);
            end
        end
    end

    task automatic send_beat(input t_in beat);
        int gap;
        gap = send_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= beat;
        do @(posedge i_clk); while (o_in_stall);
        advance_stepper(beat);
    endtask

    task automatic send_cmd(input logic [1:0] cmd, input logic [4:0] addr,
                            input logic [15:0] value);
        t_in beat;
        beat.cmd = cmd;
        beat.entry_addr = addr;
        beat.entry_value = value;
        send_beat(beat);
    endtask

    function automatic t_in random_beat();
        t_in beat;
        int r;
        beat.entry_addr = 5'($urandom_range(0, 31));
        r = $urandom_range(0, 99);
        beat.entry_value = (r < 10) ? 16'd0 : (r < 20) ? 16'hFFFF : 16'($urandom_range(0, 65535));
        r = $urandom_range(0, 99);
        if (r < 70)      beat.cmd = CMD_TICK;
        else if (r < 74) beat.cmd = CMD_HALVE;
        else if (r < 96) beat.cmd = CMD_WRITE;
        else             beat.cmd = CMD_UNUSED;
        return beat;
    endfunction

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_compares.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_INITIAL_TARGET) begin
            tgt_period = data;
            cur_period = data;
        end else if (idx == CFG_DUTY_SCALE) begin
            duty_now = data;
        end
    endtask

    task automatic set_phase(input logic [15:0] start_period, input logic [15:0] duty);
        wait_idle();
        cfg_write(CFG_INITIAL_TARGET, start_period);
        cfg_write(CFG_DUTY_SCALE, duty);
    endtask

    task automatic test_table_load();
        int i;
        for (i = 0; i < STEPS; i++) begin
            case (i)
                0: send_cmd(CMD_WRITE, 5'(i), 16'd0);
                1: send_cmd(CMD_WRITE, 5'(i), 16'hFFFF);
                2: send_cmd(CMD_WRITE, 5'(i), 16'hAAAA);
                3: send_cmd(CMD_WRITE, 5'(i), 16'h5555);
                default: send_cmd(CMD_WRITE, 5'(i), 16'($urandom_range(0, 65535)));
            endcase
        end
    endtask

    task automatic test_directed_cases();
        send_cmd(CMD_UNUSED, 5'd31, 16'hFFFF);
        send_cmd(CMD_WRITE, 5'd30, 16'hFFFF);
        send_cmd(CMD_WRITE, 5'd31, 16'h0000);
        send_cmd(CMD_TICK, 5'd0, 16'd0);
        send_cmd(CMD_HALVE, 5'd31, 16'hFFFF);
        repeat (3) send_cmd(CMD_TICK, 5'd31, 16'hFFFF);
        set_phase(PERIOD_MAX, 16'hFFFF);
        repeat (2) send_cmd(CMD_TICK, 5'd0, 16'd0);
        send_cmd(CMD_HALVE, 5'd0, 16'd0);
        set_phase(16'd0, 16'd0);
        send_cmd(CMD_TICK, 5'd0, 16'd0);
        send_cmd(CMD_HALVE, 5'd0, 16'd0);
        send_cmd(CMD_TICK, 5'd0, 16'd0);
    endtask

    // small start periods: fall past the target, clamp at zero
    task automatic test_period_settle();
        logic [15:0] start_period;
        int k;
        for (k = 0; k < 2; k++) begin
            start_period = (k == 0) ? 16'd5 : 16'd2;
            set_phase(start_period, 16'($urandom_range(0, 65535)));
            send_cmd(CMD_HALVE, 5'd0, 16'd0);
            repeat (4 * STEPS) send_cmd(CMD_TICK, 5'($urandom_range(0, 31)), 16'd0);
        end
    endtask

    task automatic test_backpressure();
        wait_idle();
        gaps_on = 1'b0;
        out_hold_cycles = 150;
        repeat (50) send_cmd(CMD_TICK, 5'd0, 16'd0);
        wait_idle();
        gaps_on = 1'b1;
    endtask

    task automatic test_drain_pause();
        repeat (30) send_beat(random_beat());
        wait_idle();
        repeat (30) send_beat(random_beat());
    endtask

    task automatic test_no_gaps();
        wait_idle();
        gaps_on = 1'b0;
        repeat (150) send_beat(random_beat());
        gaps_on = 1'b1;
    endtask

    task automatic test_random_phases();
        int p;
        for (p = 0; p < 7; p++) begin
            case (p)
                0: set_phase(16'd0, PERIOD_MAX);
                1: set_phase(PERIOD_MAX, 16'd0);
                2: set_phase(16'd3, 16'd40000);
                3: set_phase(16'd7, PERIOD_MAX);
                4: set_phase(16'd2, 16'd1);
                5: set_phase(16'($urandom_range(0, 40)), 16'($urandom_range(0, 65535)));
                default: set_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            endcase
            repeat (200) send_beat(random_beat());
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_INITIAL_TARGET;
        i_cfg_data <= '0;
        tgt_period = INITIAL_TARGET_RESET;
        cur_period = INITIAL_TARGET_RESET;
        duty_now = DUTY_SCALE_RESET;
        pos_now = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_table_load();
        test_directed_cases();
        test_period_settle();
        test_backpressure();
        test_drain_pause();
        test_no_gaps();
        test_random_phases();

        wait_idle();
        if (mismatch_count == 0 && pending_compares.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/sps_pkg.sv
hdl/sps_queue.sv
hdl/sps_front.sv
hdl/sps_back.sv
hdl/three_phase_sine_pwm_stepper_top.sv
tb/tb_top.sv
